### hdl/matrix_file_token_scanner_macros.svh
// Assertion macros for the token scanner.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef MATRIX_FILE_TOKEN_SCANNER_MACROS_SVH
`define MATRIX_FILE_TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define MFTS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed");
`define MFTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed");
`else
`define MFTS_ASSERT_IMPL(lbl, ante, cons)
`define MFTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/mfts_pkg.sv
// Shared types, constants and helpers for the token scanner.
// No dependencies.
package mfts_pkg;

    localparam int MAX_LEN = 32;
    localparam int CMD_DEPTH = 4;
    localparam int GROUP_MAX = 4;

    localparam logic [3:0] TK_NAME    = 4'd0;
    localparam logic [3:0] TK_KEYWORD = 4'd1;
    localparam logic [3:0] TK_EQUALS  = 4'd2;
    localparam logic [3:0] TK_NUMBER  = 4'd3;
    localparam logic [3:0] TK_COMMA   = 4'd4;
    localparam logic [3:0] TK_SEMI    = 4'd5;
    localparam logic [3:0] TK_LBRACK  = 4'd6;
    localparam logic [3:0] TK_RBRACK  = 4'd7;
    localparam logic [3:0] TK_EOF     = 4'd8;
    localparam logic [3:0] TK_UNK     = 4'd9;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int KW_COUNT = 3;
    localparam logic [7:0] KW_TEXT [KW_COUNT][6] = '{
        '{8'h76, 8'h61, 8'h72, 8'h73, 8'h00, 8'h00},
        '{8'h6D, 8'h61, 8'h74, 8'h72, 8'h69, 8'h78},
        '{8'h76, 8'h65, 8'h63, 8'h74, 8'h6F, 8'h72}
    };
    localparam logic [5:0] KW_LEN [KW_COUNT] = '{6'd4, 6'd6, 6'd6};

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_mark;
    } item_t;

    typedef struct packed {
        logic        item_kind;
        logic [3:0]  token_kind;
        logic [7:0]  lexeme_char;
        logic [15:0] start_line;
        logic [5:0]  lexeme_length;
        logic        final_flag;
    } result_t;

    typedef struct packed {
        logic [2:0]                  count;
        result_t [GROUP_MAX-1:0]     res;
    } cmd_t;

    function automatic result_t mk_res(input logic kind, input logic [3:0] tk,
                                       input logic [7:0] ch, input logic [15:0] line,
                                       input logic [5:0] len);
        result_t r;
        r.item_kind     = kind;
        r.token_kind    = tk;
        r.lexeme_char   = ch;
        r.start_line    = line;
        r.lexeme_length = len;
        r.final_flag    = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

### hdl/mfts_front.sv
// Front end: scans one byte per request and forms the group of results it causes.
// Depends on mfts_pkg.
module mfts_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  mfts_pkg::item_t item,
    output logic           cmd_valid,
    output mfts_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        M_IDLE, M_NAME, M_NUM, M_MINUS, M_SLASH, M_COMMENT
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] tline_reg, tline_next;
    logic [5:0]  run_reg, run_next;
    logic        bad_reg, bad_next;
    logic [2:0]  hits_reg, hits_next;

    always_comb
    begin
        logic [7:0]  c;
        logic [2:0]  cnt;
        logic        st;
        logic        word;
        logic        dig;
        logic [3:0]  tk;
        logic [15:0] line_inc;

        c        = item.char_in;
        dig      = mfts_pkg::is_digit(c);
        word     = mfts_pkg::is_alpha(c) || dig || c == mfts_pkg::CH_UNDER;
        line_inc = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
        cnt      = 3'd0;
        st       = 1'b0;
        tk       = mfts_pkg::TK_NAME;
        cmd      = '0;

        mode_next  = mode_reg;
        line_next  = line_reg;
        tline_next = tline_reg;
        run_next   = run_reg;
        bad_next   = bad_reg;
        hits_next  = hits_reg;

        // pending token ends
        if (mode_reg == M_NAME && (item.end_mark || !word
                                   || run_reg >= 6'(mfts_pkg::MAX_LEN - 1)))
        begin
            if (bad_reg)
                tk = mfts_pkg::TK_UNK;
            else
                for (int k = 0; k < mfts_pkg::KW_COUNT; k++)
                    if (hits_reg[k] && run_reg == mfts_pkg::KW_LEN[k])
                        tk = mfts_pkg::TK_KEYWORD;
            cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_END, tk, 8'h00,
                                                 tline_reg, run_reg);
            cnt = cnt + 3'd1;
            mode_next = M_IDLE;
            st = 1'b1;
        end
        else if (mode_reg == M_NUM && (item.end_mark || !word
                                       || run_reg >= 6'(mfts_pkg::MAX_LEN - 1)))
        begin
            cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_END,
                bad_reg ? mfts_pkg::TK_UNK : mfts_pkg::TK_NUMBER, 8'h00,
                tline_reg, run_reg);
            cnt = cnt + 3'd1;
            mode_next = M_IDLE;
            st = 1'b1;
        end
        else if ((mode_reg == M_MINUS && (item.end_mark || !dig))
                 || (mode_reg == M_SLASH && (item.end_mark || c != mfts_pkg::CH_SLASH)))
        begin
            cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR, mfts_pkg::TK_NAME,
                (mode_reg == M_MINUS) ? mfts_pkg::CH_MINUS : mfts_pkg::CH_SLASH,
                tline_reg, 6'd0);
            cnt = cnt + 3'd1;
            cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_END, mfts_pkg::TK_UNK,
                8'h00, tline_reg, 6'd1);
            cnt = cnt + 3'd1;
            mode_next = M_IDLE;
            st = 1'b1;
        end
        else if (!item.end_mark)
        begin
            unique case (mode_reg)
                M_NAME:
                begin
                    for (int k = 0; k < mfts_pkg::KW_COUNT; k++)
                        if (run_reg >= mfts_pkg::KW_LEN[k]
                            || mfts_pkg::KW_TEXT[k][run_reg[2:0]] != c)
                            hits_next[k] = 1'b0;
                    bad_next = bad_reg | dig;
                    cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                        mfts_pkg::TK_NAME, c, tline_reg, 6'd0);
                    cnt = cnt + 3'd1;
                    run_next = run_reg + 6'd1;
                end
                M_NUM:
                begin
                    bad_next = bad_reg | !dig;
                    cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                        mfts_pkg::TK_NAME, c, tline_reg, 6'd0);
                    cnt = cnt + 3'd1;
                    run_next = run_reg + 6'd1;
                end
                M_MINUS:
                begin
                    mode_next = M_NUM;
                    bad_next  = 1'b0;
                    cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                        mfts_pkg::TK_NAME, mfts_pkg::CH_MINUS, tline_reg, 6'd0);
                    cnt = cnt + 3'd1;
                    cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                        mfts_pkg::TK_NAME, c, tline_reg, 6'd0);
                    cnt = cnt + 3'd1;
                    run_next = 6'd2;
                end
                M_SLASH:
                    mode_next = M_COMMENT;
                M_COMMENT:
                begin
                    if (c == mfts_pkg::CH_NEWLINE)
                    begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                default:
                    st = 1'b1;
            endcase
        end
        else
            st = 1'b0;

        if (item.end_mark)
        begin
            cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_END, mfts_pkg::TK_EOF,
                8'h00, line_reg, 6'd0);
            cnt = cnt + 3'd1;
            mode_next  = M_IDLE;
            line_next  = 16'd1;
            tline_next = 16'd1;
            run_next   = 6'd0;
            bad_next   = 1'b0;
            hits_next  = 3'b111;
        end
        else if (st)
        begin
            mode_next = M_IDLE;
            if (mfts_pkg::is_space(c))
            begin
                if (c == mfts_pkg::CH_NEWLINE)
                    line_next = line_inc;
            end
            else if (mfts_pkg::is_alpha(c) || c == mfts_pkg::CH_UNDER)
            begin
                tline_next = line_reg;
                run_next   = 6'd1;
                bad_next   = 1'b0;
                for (int k = 0; k < mfts_pkg::KW_COUNT; k++)
                    hits_next[k] = (mfts_pkg::KW_TEXT[k][0] == c);
                mode_next = M_NAME;
                cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                    mfts_pkg::TK_NAME, c, line_reg, 6'd0);
                cnt = cnt + 3'd1;
            end
            else if (dig)
            begin
                tline_next = line_reg;
                run_next   = 6'd1;
                bad_next   = 1'b0;
                hits_next  = 3'b111;
                mode_next  = M_NUM;
                cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                    mfts_pkg::TK_NAME, c, line_reg, 6'd0);
                cnt = cnt + 3'd1;
            end
            else if (c == mfts_pkg::CH_MINUS || c == mfts_pkg::CH_SLASH)
            begin
                tline_next = line_reg;
                mode_next  = (c == mfts_pkg::CH_MINUS) ? M_MINUS : M_SLASH;
            end
            else
            begin
                priority if (c == mfts_pkg::CH_EQUALS)
                    tk = mfts_pkg::TK_EQUALS;
                else if (c == mfts_pkg::CH_COMMA)
                    tk = mfts_pkg::TK_COMMA;
                else if (c == mfts_pkg::CH_SEMI)
                    tk = mfts_pkg::TK_SEMI;
                else if (c == mfts_pkg::CH_LBRACK)
                    tk = mfts_pkg::TK_LBRACK;
                else if (c == mfts_pkg::CH_RBRACK)
                    tk = mfts_pkg::TK_RBRACK;
                else
                    tk = mfts_pkg::TK_UNK;
                tline_next = line_reg;
                cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_CHAR,
                    mfts_pkg::TK_NAME, c, line_reg, 6'd0);
                cnt = cnt + 3'd1;
                cmd.res[cnt[1:0]] = mfts_pkg::mk_res(mfts_pkg::KIND_END, tk, 8'h00,
                    line_reg, 6'd1);
                cnt = cnt + 3'd1;
            end
        end

        for (int i = 0; i < mfts_pkg::GROUP_MAX; i++)
            cmd.res[i].final_flag = (3'(i) + 3'd1 == cnt);
        cmd.count = cnt;
        cmd_valid = accept && (cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            line_reg  <= 16'd1;
            tline_reg <= 16'd1;
            run_reg   <= 6'd0;
            bad_reg   <= 1'b0;
            hits_reg  <= 3'b111;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            tline_reg <= tline_next;
            run_reg   <= run_next;
            bad_reg   <= bad_next;
            hits_reg  <= hits_next;
        end
    end

endmodule

### hdl/mfts_queue.sv
// Short queue of result groups between front and back ends.
// Depends on mfts_pkg.
module mfts_queue
#(
    parameter int DEPTH = mfts_pkg::CMD_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mfts_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output mfts_pkg::cmd_t rd_data,
    output logic           full,
    output logic           empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mfts_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr_en)
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        if (rd_en)
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CW'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[tail_reg] <= wr_data;
    end

endmodule

### hdl/mfts_back.sv
// Back end: walks the head group and hands out one result per request.
// Depends on mfts_pkg.
module mfts_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  mfts_pkg::cmd_t    head,
    input  logic              q_empty,
    input  logic              pop,
    output logic              group_done,
    output logic              empty,
    output mfts_pkg::result_t result
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign empty      = q_empty;
    assign result     = head.res[idx_reg];
    assign take       = pop && !q_empty;
    assign group_done = take && ({1'b0, idx_reg} == head.count - 3'd1);

    always_comb
    begin
        idx_next = idx_reg;
        if (group_done)
            idx_next = 2'd0;
        else if (take)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

### hdl/matrix_file_token_scanner.sv
// Token scanner for the matrix description language: one byte (or end mark) per
// request, tokens out as lexeme characters plus a token end. A byte is taken every
// cycle while the group queue (CMD_DEPTH groups) has room; the output side hands
// out one result per cycle while pop is high and a group waits, and the queue
// absorbs bytes that cause two to four results; groups are registered in the queue.
module matrix_file_token_scanner
#(
    parameter int CMD_DEPTH = mfts_pkg::CMD_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mfts_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output mfts_pkg::result_t result
);

`include "matrix_file_token_scanner_macros.svh"

    logic           accept;
    logic           cmd_valid;
    mfts_pkg::cmd_t cmd;
    mfts_pkg::cmd_t head;
    logic           q_empty;
    logic           group_done;

    assign accept = push && !full;

    mfts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    mfts_queue #(.DEPTH(CMD_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (group_done),
        .rd_data (head),
        .full    (full),
        .empty   (q_empty)
    );

    mfts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .group_done (group_done),
        .empty      (empty),
        .result     (result)
    );

    `MFTS_ASSERT_NEXT(a_group_continues, !empty && pop && !result.final_flag, !empty)
    `MFTS_ASSERT_IMPL(a_end_has_no_char, !empty && result.item_kind, result.lexeme_char == 8'd0)
    `MFTS_ASSERT_IMPL(a_not_full_and_empty, full, !empty)

endmodule
